// File: hdl/pts_pkg.sv
`timescale 1ns / 1ps

package pts_pkg;

  // Table geometry.
  localparam int SLOTS     = 16;
  localparam int MAX_LEVEL = 31;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int LVL_W     = $clog2(MAX_LEVEL + 1);
  localparam int WAIT_W    = 32;
  localparam int TICK_W    = 32;

  // Beat widths on the stream ports (whole bytes).
  localparam int IN_W  = 48;
  localparam int OUT_W = 48;

  // Command codes.
  localparam logic [2:0] CMD_CREATE   = 3'd0;
  localparam logic [2:0] CMD_DELETE   = 3'd1;
  localparam logic [2:0] CMD_DELAY    = 3'd2;
  localparam logic [2:0] CMD_TICK     = 3'd3;
  localparam logic [2:0] CMD_SCHEDULE = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NORUN   = 2'd2;
  localparam logic [1:0] ST_NOREADY = 2'd3;

  // One slot entry as it streams out of the table during a scan.
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic [LVL_W-1:0] prio;
    logic             ready;
  } scan_beat_t;

  // Round-robin context for a pick.
  typedef struct packed {
    logic             en;
    logic [LVL_W-1:0] lvl;
    logic [IDX_W-1:0] last;
  } rr_cfg_t;

  // Outcome of a pick.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_res_t;

endpackage

// File: hdl/pts_ram.sv
`timescale 1ns / 1ps

module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/pts_picker.sv
`timescale 1ns / 1ps

module pts_picker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear,
  input  pts_pkg::rr_cfg_t    rr,
  input  pts_pkg::scan_beat_t beat,
  output pts_pkg::pick_res_t  res
);
  import pts_pkg::*;

  logic             rr_found_r, rr_found_nxt;
  logic [IDX_W-1:0] rr_idx_r, rr_idx_nxt;
  logic             mn_found_r, mn_found_nxt;
  logic [IDX_W-1:0] mn_idx_r, mn_idx_nxt;
  logic [LVL_W-1:0] mn_prio_r, mn_prio_nxt;

  // Track the first ready slot of the same level after the last pick, and the
  // first ready slot of the lowest level, as the entries stream by in order.
  always_comb begin
    rr_found_nxt = rr_found_r;
    rr_idx_nxt   = rr_idx_r;
    mn_found_nxt = mn_found_r;
    mn_idx_nxt   = mn_idx_r;
    mn_prio_nxt  = mn_prio_r;
    if (clear) begin
      rr_found_nxt = 1'b0;
      mn_found_nxt = 1'b0;
    end else if (beat.vld && beat.ready) begin
      if (!rr_found_r && rr.en && beat.idx > rr.last && beat.prio == rr.lvl) begin
        rr_found_nxt = 1'b1;
        rr_idx_nxt   = beat.idx;
      end
      if (!mn_found_r || beat.prio < mn_prio_r) begin
        mn_found_nxt = 1'b1;
        mn_idx_nxt   = beat.idx;
        mn_prio_nxt  = beat.prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_found_r <= 1'b0;
      mn_found_r <= 1'b0;
    end else begin
      rr_found_r <= rr_found_nxt;
      mn_found_r <= mn_found_nxt;
    end
    rr_idx_r  <= rr_idx_nxt;
    mn_idx_r  <= mn_idx_nxt;
    mn_prio_r <= mn_prio_nxt;
  end

  // Round robin wins over the lowest-level search.
  assign res.found = rr_found_r | mn_found_r;
  assign res.idx   = rr_found_r ? rr_idx_r : mn_idx_r;

endmodule

// File: hdl/priority_task_scheduler.sv
`timescale 1ns / 1ps
// Create, commands without a running task, disabled ticks and unknown commands
// go straight to the result. Delete, delay, enabled tick and schedule scan the slot
// memories one entry a cycle and then pick the next task.
// Throughput: one command at a time; the next beat is taken once the result is registered.
// Reset (rst_n low, synchronous) frees all slots, clears the running task,
// the round-robin mark and the tick counter, and enables scheduling.
module priority_task_scheduler (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input beat fields from bit 0: cmd[2:0], level[10:3], delay_ticks[42:11].
  input  logic [pts_pkg::IN_W-1:0]  in_tdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // Result beat fields from bit 0: status[1:0], slot[5:2], running_valid[6],
  // running_slot[10:7], tick_count[42:11].
  output logic [pts_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_data
);
  import pts_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LVL   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [SLOTS-1:0]  used_r, used_nxt;
  logic              run_v_r, run_v_nxt;
  logic [IDX_W-1:0]  run_idx_r, run_idx_nxt;
  logic              last_v_r, last_v_nxt;
  logic [IDX_W-1:0]  last_idx_r, last_idx_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic              en_r;
  logic              tick_mode_r, tick_mode_nxt;
  logic              rr_en_r, rr_en_nxt;
  logic [LVL_W-1:0]  rr_lvl_r;
  logic              lvl_pend_r;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              proc_v_r;
  logic [IDX_W-1:0]  proc_idx_r;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_slot_r, res_slot_nxt;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [2:0]        in_cmd;
  logic [7:0]        in_level;
  logic [WAIT_W-1:0] in_delay;
  logic              in_take;
  logic              out_load;

  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [LVL_W-1:0]  level_clamp;

  logic              prio_we;
  logic [IDX_W-1:0]  prio_waddr;
  logic [LVL_W-1:0]  prio_wdata;
  logic [IDX_W-1:0]  prio_raddr;
  logic [LVL_W-1:0]  prio_rdata;
  logic              wait_we;
  logic [IDX_W-1:0]  wait_waddr;
  logic [WAIT_W-1:0] wait_wdata;
  logic [WAIT_W-1:0] wait_rdata;

  logic              beat_used;
  logic              beat_dec;
  logic [WAIT_W-1:0] beat_wait;
  scan_beat_t        beat;
  rr_cfg_t           rr;
  pick_res_t         pres;
  logic              pick_clear;

  // Input beat unpacking.
  assign in_cmd   = in_tdata[2:0];
  assign in_level = in_tdata[10:3];
  assign in_delay = in_tdata[42:11];
  assign in_tready = (state_r == S_IDLE);
  assign in_take   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // First free slot for create.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign level_clamp = (in_level > 8'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : LVL_W'(in_level);

  // Scan beat: apply the tick decrement on the fly and judge readiness.
  assign beat_used = used_r[proc_idx_r];
  assign beat_dec  = proc_v_r && tick_mode_r && beat_used && (wait_rdata != '0);
  assign beat_wait = beat_dec ? (wait_rdata - 1'b1) : wait_rdata;

  assign beat.vld   = proc_v_r;
  assign beat.idx   = proc_idx_r;
  assign beat.prio  = prio_rdata;
  assign beat.ready = beat_used && (beat_wait == '0);

  assign rr.en   = rr_en_r;
  assign rr.lvl  = rr_lvl_r;
  assign rr.last = last_idx_r;

  assign pick_clear = (state_r == S_LVL);

  // Memory port steering.
  always_comb begin
    prio_we    = 1'b0;
    prio_waddr = free_idx;
    prio_wdata = level_clamp;
    wait_we    = 1'b0;
    wait_waddr = free_idx;
    wait_wdata = '0;
    if (in_take && in_cmd == CMD_CREATE && free_found) begin
      prio_we = 1'b1;
      wait_we = 1'b1;
    end else if (in_take && in_cmd == CMD_DELAY && run_v_r) begin
      wait_we    = 1'b1;
      wait_waddr = run_idx_r;
      wait_wdata = in_delay;
    end else if (beat_dec) begin
      wait_we    = 1'b1;
      wait_waddr = proc_idx_r;
      wait_wdata = beat_wait;
    end
  end

  assign prio_raddr = (state_r == S_LVL) ? last_idx_r : rd_idx_r;

  pts_ram #(.WIDTH(LVL_W), .DEPTH(SLOTS)) u_prio_ram (
    .clk   (clk),
    .we    (prio_we),
    .waddr (prio_waddr),
    .wdata (prio_wdata),
    .raddr (prio_raddr),
    .rdata (prio_rdata)
  );

  pts_ram #(.WIDTH(WAIT_W), .DEPTH(SLOTS)) u_wait_ram (
    .clk   (clk),
    .we    (wait_we),
    .waddr (wait_waddr),
    .wdata (wait_wdata),
    .raddr (rd_idx_r),
    .rdata (wait_rdata)
  );

  pts_picker u_picker (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (pick_clear),
    .rr    (rr),
    .beat  (beat),
    .res   (pres)
  );

  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // Command sequencer.
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    run_v_nxt      = run_v_r;
    run_idx_nxt    = run_idx_r;
    last_v_nxt     = last_v_r;
    last_idx_nxt   = last_idx_r;
    ticks_nxt      = ticks_r;
    tick_mode_nxt  = tick_mode_r;
    rr_en_nxt      = rr_en_r;
    rd_idx_nxt     = rd_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          res_status_nxt = ST_OK;
          res_slot_nxt   = '0;
          tick_mode_nxt  = 1'b0;
          state_nxt      = S_FIN;
          priority case (in_cmd)
            CMD_CREATE: begin
              if (free_found) begin
                used_nxt[free_idx] = 1'b1;
                res_slot_nxt       = free_idx;
              end else begin
                res_status_nxt = ST_FULL;
              end
            end
            CMD_DELETE: begin
              if (!run_v_r) begin
                res_status_nxt = ST_NORUN;
              end else begin
                used_nxt[run_idx_r] = 1'b0;
                if (last_v_r && last_idx_r == run_idx_r) begin
                  last_v_nxt   = 1'b0;
                  last_idx_nxt = '0;
                end
                state_nxt = S_LVL;
              end
            end
            CMD_DELAY: begin
              if (!run_v_r) begin
                res_status_nxt = ST_NORUN;
              end else begin
                state_nxt = S_LVL;
              end
            end
            CMD_TICK: begin
              if (en_r) begin
                ticks_nxt     = ticks_r + 1'b1;
                tick_mode_nxt = 1'b1;
                state_nxt     = S_LVL;
              end
            end
            CMD_SCHEDULE: begin
              if (en_r) begin
                state_nxt = S_LVL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LVL: begin
        rr_en_nxt  = last_v_r && used_r[last_idx_r];
        rd_idx_nxt = '0;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (rd_idx_r == LAST_IDX) begin
          rd_idx_nxt = '0;
          state_nxt  = S_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (pres.found) begin
          run_v_nxt      = 1'b1;
          run_idx_nxt    = pres.idx;
          last_v_nxt     = 1'b1;
          last_idx_nxt   = pres.idx;
          res_status_nxt = ST_OK;
          res_slot_nxt   = pres.idx;
        end else begin
          run_v_nxt      = 1'b0;
          run_idx_nxt    = '0;
          last_v_nxt     = 1'b0;
          last_idx_nxt   = '0;
          res_status_nxt = ST_NOREADY;
          res_slot_nxt   = '0;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      run_v_r     <= 1'b0;
      run_idx_r   <= '0;
      last_v_r    <= 1'b0;
      last_idx_r  <= '0;
      ticks_r     <= '0;
      en_r        <= 1'b1;
      tick_mode_r <= 1'b0;
      rr_en_r     <= 1'b0;
      lvl_pend_r  <= 1'b0;
      rd_idx_r    <= '0;
      proc_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      run_v_r     <= run_v_nxt;
      run_idx_r   <= run_idx_nxt;
      last_v_r    <= last_v_nxt;
      last_idx_r  <= last_idx_nxt;
      ticks_r     <= ticks_nxt;
      tick_mode_r <= tick_mode_nxt;
      rr_en_r     <= rr_en_nxt;
      lvl_pend_r  <= (state_r == S_LVL);
      rd_idx_r    <= rd_idx_nxt;
      proc_v_r    <= (state_r == S_SCAN);
      if (cfg_valid && cfg_ready) begin
        en_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    proc_idx_r   <= rd_idx_r;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    // The level of the last picked slot arrives in the cycle after its read.
    if (lvl_pend_r) begin
      rr_lvl_r <= prio_rdata;
    end
    if (out_load) begin
      out_data_r <= {5'd0, ticks_r,
                     run_v_r ? 4'(run_idx_r) : 4'd0,
                     run_v_r,
                     4'(res_slot_r),
                     res_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A settled running task always points at a live slot.
  a_run_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && run_v_r) |-> used_r[run_idx_r])
    else $error("running task points at a free slot");

  // The round-robin mark only ever names the running task.
  a_last_is_run: assert property (@(posedge clk) disable iff (!rst_n)
    last_v_r |-> (run_v_r && last_idx_r == run_idx_r))
    else $error("round-robin mark differs from running task");

  // A failed pick leaves no running task behind.
  a_noready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == ST_NOREADY) |-> !out_tdata[6])
    else $error("no-ready result still shows a running task");

  // Scan write-backs only happen on tick commands.
  a_scan_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_v_r && wait_we) |-> tick_mode_r)
    else $error("delay write-back outside a tick");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

// One result beat, laid out as on out_tdata (status in the lowest bits).
typedef struct packed {
  logic [4:0]  pad;
  logic [31:0] tick_count;
  logic [3:0]  running_slot;
  logic        running_valid;
  logic [3:0]  slot;
  logic [1:0]  status;
} sched_beat_t;

// Shadow of the task table. Every accepted command beat is applied here and
// the result it should produce is queued for comparison with the DUT output.
class sched_scoreboard;
  bit                          used [pts_pkg::SLOTS];
  bit [pts_pkg::LVL_W-1:0]     level [pts_pkg::SLOTS];
  bit [pts_pkg::WAIT_W-1:0]    wait_left [pts_pkg::SLOTS];
  bit                          run_valid;
  bit [pts_pkg::IDX_W-1:0]     run_slot;
  bit                          rr_valid;
  bit [pts_pkg::IDX_W-1:0]     rr_slot;
  bit [pts_pkg::TICK_W-1:0]    tick_count;
  bit                          sched_en = 1'b1;
  sched_beat_t                 reports [$];
  int                          errors;

  function bit is_ready(int i);
    return used[i] && wait_left[i] == 0;
  endfunction

  // Round robin within the level of the last pick, then the most urgent
  // ready task. An empty ready set clears the running task and the memory.
  function logic [1:0] choose_next_task(output logic [pts_pkg::IDX_W-1:0] picked);
    bit                      found;
    int                      best;
    bit [pts_pkg::LVL_W-1:0] lvl;
    found = 1'b0;
    best  = 0;
    if (rr_valid && used[rr_slot]) begin
      lvl = level[rr_slot];
      for (int i = int'(rr_slot) + 1; i < pts_pkg::SLOTS; i++) begin
        if (!found && is_ready(i) && level[i] == lvl) begin
          found = 1'b1;
          best  = i;
        end
      end
    end
    if (!found) begin
      for (int i = 0; i < pts_pkg::SLOTS; i++) begin
        if (is_ready(i) && (!found || level[i] < level[best])) begin
          found = 1'b1;
          best  = i;
        end
      end
    end
    if (!found) begin
      run_valid = 1'b0;
      run_slot  = '0;
      rr_valid  = 1'b0;
      rr_slot   = '0;
      picked    = '0;
      return pts_pkg::ST_NOREADY;
    end
    run_valid = 1'b1;
    run_slot  = pts_pkg::IDX_W'(best);
    rr_valid  = 1'b1;
    rr_slot   = pts_pkg::IDX_W'(best);
    picked    = pts_pkg::IDX_W'(best);
    return pts_pkg::ST_OK;
  endfunction

  // Applies one accepted command beat and queues the result it must cause.
  function void note_command(logic [2:0] cmd, logic [7:0] lvl_in, logic [31:0] dly);
    sched_beat_t                 exp_beat;
    int                          free_slot;
    bit [pts_pkg::LVL_W-1:0]     clamped;
    logic [pts_pkg::IDX_W-1:0]   picked;
    exp_beat  = '0;
    free_slot = -1;
    picked    = '0;
    case (cmd)
      pts_pkg::CMD_CREATE: begin
        exp_beat.status = pts_pkg::ST_FULL;
        for (int i = 0; i < pts_pkg::SLOTS; i++) begin
          if (!used[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot >= 0) begin
          clamped = (lvl_in > pts_pkg::MAX_LEVEL) ? pts_pkg::LVL_W'(pts_pkg::MAX_LEVEL)
                                                  : pts_pkg::LVL_W'(lvl_in);
          used[free_slot]      = 1'b1;
          level[free_slot]     = clamped;
          wait_left[free_slot] = '0;
          exp_beat.slot        = 4'(free_slot);
          exp_beat.status      = pts_pkg::ST_OK;
        end
      end
      pts_pkg::CMD_DELETE: begin
        if (!run_valid) begin
          exp_beat.status = pts_pkg::ST_NORUN;
        end else begin
          used[run_slot] = 1'b0;
          if (rr_valid && rr_slot == run_slot) begin
            rr_valid = 1'b0;
            rr_slot  = '0;
          end
          exp_beat.status = choose_next_task(picked);
          exp_beat.slot   = picked;
        end
      end
      pts_pkg::CMD_DELAY: begin
        if (!run_valid) begin
          exp_beat.status = pts_pkg::ST_NORUN;
        end else begin
          wait_left[run_slot] = dly;
          exp_beat.status = choose_next_task(picked);
          exp_beat.slot   = picked;
        end
      end
      pts_pkg::CMD_TICK: begin
        if (sched_en) begin
          tick_count++;
          for (int i = 0; i < pts_pkg::SLOTS; i++) begin
            if (used[i] && wait_left[i] != 0) wait_left[i]--;
          end
          exp_beat.status = choose_next_task(picked);
          exp_beat.slot   = picked;
        end
      end
      pts_pkg::CMD_SCHEDULE: begin
        if (sched_en) begin
          exp_beat.status = choose_next_task(picked);
          exp_beat.slot   = picked;
        end
      end
      default: begin
        // Spare command codes leave the table untouched.
      end
    endcase
    exp_beat.running_valid = run_valid;
    exp_beat.running_slot  = run_valid ? run_slot : '0;
    exp_beat.tick_count    = tick_count;
    reports.push_back(exp_beat);
  endfunction

  // Compares one result beat against the oldest queued result.
  function void check_result(logic [pts_pkg::OUT_W-1:0] data);
    sched_beat_t got;
    sched_beat_t want;
    got = data;
    if (reports.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result beat %h arrived with nothing outstanding", data);
      return;
    end
    want = reports.pop_front();
    if (got.status !== want.status || got.slot !== want.slot ||
        got.running_valid !== want.running_valid ||
        got.running_slot !== want.running_slot ||
        got.tick_count !== want.tick_count || got.pad !== want.pad) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: expected status %0d slot %0d run %0d/%0d ticks %0d pad %h",
                 want.status, want.slot, want.running_valid, want.running_slot,
                 want.tick_count, want.pad);
        $display("          actual   status %0d slot %0d run %0d/%0d ticks %0d pad %h",
                 got.status, got.slot, got.running_valid, got.running_slot,
                 got.tick_count, got.pad);
      end
    end
  endfunction
endclass

module tb;
  import pts_pkg::*;

  // Spare command codes that the block must ignore.
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic             cfg_data   = 1'b0;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  sched_scoreboard sb = new();

  priority_task_scheduler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  // Result side: random backpressure and checking of every accepted beat.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Presents one command beat, with random idle cycles ahead of it, and
  // records it once taken. The valid stays up for a following beat.
  task automatic send_command(input logic [2:0] cmd, input logic [7:0] lvl,
                              input logic [31:0] dly);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {5'd0, dly, lvl, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, lvl, dly);
  endtask

  // Waits until every outstanding result is back and the block has settled.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.reports.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
  endtask

  task automatic write_sched_enable(input logic value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.sched_en = value;
  endtask

  // Random traffic: creates outweigh deletes so the table fills up, levels
  // cluster on a few values so round robin among equals gets exercised, and
  // delays are mostly short so tasks come back to ready.
  task automatic run_mix(input int count);
    logic [2:0]  cmd;
    logic [7:0]  lvl;
    logic [31:0] dly;
    int          r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 33)      cmd = CMD_CREATE;
      else if (r < 48) cmd = CMD_DELETE;
      else if (r < 63) cmd = CMD_DELAY;
      else if (r < 83) cmd = CMD_TICK;
      else if (r < 95) cmd = CMD_SCHEDULE;
      else             cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
      r = $urandom_range(99);
      if (r < 65)      lvl = 8'($urandom_range(3, 0));
      else if (r < 90) lvl = 8'($urandom_range(MAX_LEVEL, 0));
      else             lvl = 8'($urandom_range(8'hFF, 0));
      r = $urandom_range(99);
      if (r < 55)      dly = '0;
      else if (r < 96) dly = $urandom_range(5, 1);
      else             dly = $urandom;
      send_command(cmd, lvl, dly);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_sched_enable(1'b1);

    // Directed: empty table, no running task, spare codes, level clamping,
    // round robin within a level, delays, and deleting the picked task.
    send_command(CMD_SCHEDULE, 8'd0, 32'd0);
    send_command(CMD_TICK, 8'd0, 32'd0);
    send_command(CMD_DELETE, 8'd0, 32'd0);
    send_command(CMD_DELAY, 8'd0, 32'hFFFF_FFFF);
    send_command(CMD_SPARE_FIRST, 8'hFF, 32'hFFFF_FFFF);
    send_command(CMD_SPARE_MID, 8'hA5, 32'h5A5A_A5A5);
    send_command(CMD_SPARE_LAST, 8'h00, 32'h0000_0000);
    send_command(CMD_CREATE, 8'hFF, 32'd0);
    send_command(CMD_CREATE, 8'd0, 32'd0);
    send_command(CMD_CREATE, 8'd32, 32'd0);
    send_command(CMD_CREATE, 8'd31, 32'd0);
    send_command(CMD_SCHEDULE, 8'd0, 32'd0);
    send_command(CMD_DELAY, 8'd0, 32'd2);
    send_command(CMD_SCHEDULE, 8'd0, 32'd0);
    send_command(CMD_SCHEDULE, 8'd0, 32'd0);
    send_command(CMD_TICK, 8'd0, 32'd0);
    send_command(CMD_TICK, 8'd0, 32'd0);
    send_command(CMD_DELETE, 8'd0, 32'd0);
    send_command(CMD_DELAY, 8'd0, 32'd1);
    send_command(CMD_TICK, 8'd0, 32'd0);
    send_command(CMD_DELETE, 8'd0, 32'd0);
    send_command(CMD_DELAY, 8'd0, 32'hFFFF_FFFF);
    send_command(CMD_DELETE, 8'd0, 32'd0);
    send_command(CMD_DELETE, 8'd0, 32'd0);
    run_mix(100);
    drain_results();

    // Scheduling off, with a mostly idle sender.
    write_sched_enable(1'b0);
    tx_idle_pct = 73;
    run_mix(40);
    drain_results();

    // Scheduling back on under receiver stalls, then stalls on both sides.
    write_sched_enable(1'b1);
    tx_idle_pct  = 0;
    rx_stall_pct = 73;
    run_mix(110);
    tx_idle_pct  = 36;
    rx_stall_pct = 36;
    run_mix(110);
    drain_results();

    write_sched_enable(1'b0);
    run_mix(30);
    drain_results();

    write_sched_enable(1'b1);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_mix(40);
    drain_results();

    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule

// File: files.f
hdl/pts_pkg.sv
hdl/pts_ram.sv
hdl/pts_picker.sv
hdl/priority_task_scheduler.sv
tb/tb.sv
